// ----- design/rlfb_pkg.sv -----
// Shared types and constants for the LED chain frame builder.
`default_nettype none

package rlfb_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_BRIGHT = 2'd1,
    OP_SEND   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_LED   = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  localparam logic REG_RING_LENGTH = 1'b0;
  localparam logic REG_LED_COUNT   = 1'b1;

  localparam logic [5:0] RING_LENGTH_RST = 6'd32;
  localparam logic [5:0] LED_COUNT_RST   = 6'd4;
  localparam logic [5:0] FRAME_LED_MAX   = 6'd32;

  localparam logic [2:0]  LED_HEADER = 3'b111;
  localparam logic [31:0] START_WORD = 32'h0000_0000;
  localparam logic [31:0] END_WORD   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [5:0] ring_length;
    logic [5:0] led_count;
  } cfg_t;

  typedef struct packed {
    logic        wr_color;
    logic        wr_bright;
    logic [4:0]  bright;
    logic [23:0] color;
  } store_wr_t;

endpackage

`default_nettype wire

// ----- design/rgb_led_chain_frame_builder.sv -----
// Top level of the LED chain frame builder: configuration registers and block wiring.
//
// Requests arrive on the in_ channel (valid/ready). A write request sets one LED entry.
// A brightness request rewrites the brightness of the leading entries, one entry per
// cycle, and keeps the block busy until that sweep ends. A send request produces a frame
// on the out_ channel: a start word of zeros, led_count LED words {111, brightness,
// blue, green, red} read from a ring over the store, and an all-ones end word flagged by
// out_last_word. The first word is loaded into the output register in the start state,
// which the request enters on acceptance, and words then follow one per cycle while the
// receiver takes them; the pace is set by the single read port of the LED store, whose
// read address runs one entry ahead of the output register. in_ready is low from
// acceptance until the end word has been loaded into the output register.
// A stalled receiver simply freezes the sequencer: the output register holds its word
// and the store read address holds, so nothing is lost or repeated.
// After reset the store is cleared by a pass over every entry during which no request
// is accepted; ring_length resets to 32 and led_count to 4. The APB port must be
// written only while the block is idle; the block itself does not enforce this.
`default_nettype none

module rgb_led_chain_frame_builder #(
  parameter int STORE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [4:0]  in_position,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [4:0]  in_brightness,
  input  wire logic [5:0]  in_entry_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_frame_word,
  output logic [1:0]       out_word_kind,
  output logic             out_last_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IdxW  = (AddrW > 6) ? AddrW : 6;

  logic [5:0]          ring_length_r;
  logic [5:0]          led_count_r;
  logic                cfg_wr;
  rlfb_pkg::cfg_t      cfg;
  logic [AddrW-1:0]    wr_addr;
  rlfb_pkg::store_wr_t wr;
  logic [AddrW-1:0]    rd_addr;
  logic [4:0]          rd_bright;
  logic [23:0]         rd_color;

  // Registers sit at byte addresses 0 and 4; bit 2 of the address picks one.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_length_r <= rlfb_pkg::RING_LENGTH_RST;
      led_count_r   <= rlfb_pkg::LED_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == rlfb_pkg::REG_RING_LENGTH) begin
        ring_length_r <= pwdata[5:0];
      end else begin
        led_count_r <= pwdata[5:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rlfb_pkg::REG_LED_COUNT) begin
      prdata = {26'd0, led_count_r};
    end else begin
      prdata = {26'd0, ring_length_r};
    end
  end

  assign cfg.ring_length = ring_length_r;
  assign cfg.led_count   = led_count_r;

  rlfb_ctrl #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW),
    .IdxW  (IdxW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_brightness  (in_brightness),
    .in_entry_count (in_entry_count),
    .cfg            (cfg),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_word (out_frame_word),
    .out_word_kind  (out_word_kind),
    .out_last_word  (out_last_word),
    .wr_addr        (wr_addr),
    .wr             (wr),
    .rd_addr        (rd_addr),
    .rd_bright      (rd_bright),
    .rd_color       (rd_color)
  );

  rlfb_store #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk       (clk),
    .wr_addr   (wr_addr),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_bright (rd_bright),
    .rd_color  (rd_color)
  );

endmodule

`default_nettype wire

// ----- design/rlfb_store.sv -----
// LED entry store: color and brightness arrays, one write port, registered read.
`default_nettype none

module rlfb_store #(
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  wire logic                clk,
  input  wire logic [AddrW-1:0]    wr_addr,
  input  wire rlfb_pkg::store_wr_t wr,
  input  wire logic [AddrW-1:0]    rd_addr,
  output logic [4:0]               rd_bright,
  output logic [23:0]              rd_color
);

  logic [23:0] color_mem  [Depth];
  logic [4:0]  bright_mem [Depth];
  logic [23:0] rd_color_r;
  logic [4:0]  rd_bright_r;

  // Brightness is a separate array so a brightness sweep needs no read.
  always_ff @(posedge clk) begin
    if (wr.wr_color) begin
      color_mem[wr_addr] <= wr.color;
    end
    if (wr.wr_bright) begin
      bright_mem[wr_addr] <= wr.bright;
    end
    rd_color_r  <= color_mem[rd_addr];
    rd_bright_r <= bright_mem[rd_addr];
  end

  assign rd_color  = rd_color_r;
  assign rd_bright = rd_bright_r;

endmodule

`default_nettype wire

// ----- design/rlfb_ctrl.sv -----
// Sequencer: clear pass, entry writes, brightness sweep and frame emission.
`default_nettype none

module rlfb_ctrl #(
  parameter int Depth = 32,
  parameter int AddrW = 5,
  parameter int IdxW  = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_opcode,
  input  wire logic [4:0]           in_position,
  input  wire logic [7:0]           in_red,
  input  wire logic [7:0]           in_green,
  input  wire logic [7:0]           in_blue,
  input  wire logic [4:0]           in_brightness,
  input  wire logic [5:0]           in_entry_count,
  input  wire rlfb_pkg::cfg_t       cfg,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               out_frame_word,
  output logic [1:0]                out_word_kind,
  output logic                      out_last_word,
  output logic [AddrW-1:0]          wr_addr,
  output rlfb_pkg::store_wr_t       wr,
  output logic [AddrW-1:0]          rd_addr,
  input  wire logic [4:0]           rd_bright,
  input  wire logic [23:0]          rd_color
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BRIGHT,
    ST_START,
    ST_LED,
    ST_END
  } state_t;

  localparam logic [5:0]      DEPTH_CAP = (Depth > 63) ? 6'd63 : 6'(Depth);
  localparam logic [IdxW-1:0] LAST_IDX  = IdxW'(Depth - 1);

  state_t              state_r, state_nxt;
  logic [IdxW-1:0]     idx_r, idx_nxt;
  logic [5:0]          rem_r, rem_nxt;
  logic [5:0]          len_r, len_nxt;
  logic [4:0]          bright_r, bright_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_word_r, out_word_nxt;
  rlfb_pkg::kind_t     out_kind_r, out_kind_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept;
  logic                slot_free;
  logic                load;
  logic [5:0]          len_eff;
  logic [5:0]          n_eff;
  logic [5:0]          pos_eff;
  logic [5:0]          cnt_eff;
  logic                in_range;
  logic [IdxW-1:0]     idx_inc;
  logic [IdxW-1:0]     led_next;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign load      = slot_free &&
                     ((state_r == ST_START) || (state_r == ST_LED) || (state_r == ST_END));

  always_comb begin
    if (cfg.ring_length == 6'd0) begin
      len_eff = 6'd1;
    end else if (cfg.ring_length > DEPTH_CAP) begin
      len_eff = DEPTH_CAP;
    end else begin
      len_eff = cfg.ring_length;
    end
  end

  assign n_eff    = (cfg.led_count > rlfb_pkg::FRAME_LED_MAX) ? rlfb_pkg::FRAME_LED_MAX
                                                               : cfg.led_count;
  assign pos_eff  = ({1'b0, in_position} >= len_eff) ? 6'd0 : {1'b0, in_position};
  assign cnt_eff  = (in_entry_count > DEPTH_CAP) ? DEPTH_CAP : in_entry_count;
  assign in_range = (int'(in_position) < Depth);
  assign idx_inc  = idx_r + IdxW'(1);
  assign led_next = (idx_inc >= IdxW'(len_r)) ? '0 : idx_inc;

  // The read address runs one entry ahead whenever an LED word is taken,
  // so the registered read data always belongs to idx_r while sending.
  assign rd_addr = (state_r == ST_LED && load) ? AddrW'(led_next) : AddrW'(idx_r);

  always_comb begin
    wr      = '0;
    wr_addr = AddrW'(idx_r);
    case (state_r)
      ST_CLEAR: begin
        wr.wr_color  = 1'b1;
        wr.wr_bright = 1'b1;
      end
      ST_BRIGHT: begin
        wr.wr_bright = 1'b1;
        wr.bright    = bright_r;
      end
      ST_IDLE: begin
        if (accept && in_opcode == rlfb_pkg::OP_WRITE && in_range) begin
          wr.wr_color  = 1'b1;
          wr.wr_bright = 1'b1;
          wr.color     = {in_blue, in_green, in_red};
          wr.bright    = in_brightness;
          wr_addr      = AddrW'(in_position);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    len_nxt       = len_r;
    bright_nxt    = bright_r;
    out_word_nxt  = out_word_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    unique case (state_r)
      ST_CLEAR: begin
        idx_nxt = idx_inc;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
          idx_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            rlfb_pkg::OP_BRIGHT: begin
              if (cnt_eff != 6'd0) begin
                state_nxt  = ST_BRIGHT;
                idx_nxt    = '0;
                rem_nxt    = cnt_eff;
                bright_nxt = in_brightness;
              end
            end
            rlfb_pkg::OP_SEND: begin
              state_nxt = ST_START;
              idx_nxt   = IdxW'(pos_eff);
              len_nxt   = len_eff;
              rem_nxt   = n_eff;
            end
            default: ;
          endcase
        end
      end
      ST_BRIGHT: begin
        idx_nxt = idx_inc;
        rem_nxt = rem_r - 6'd1;
        if (rem_r == 6'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_START: begin
        if (load) begin
          out_word_nxt = rlfb_pkg::START_WORD;
          out_kind_nxt = rlfb_pkg::KIND_START;
          out_last_nxt = 1'b0;
          state_nxt    = (rem_r == 6'd0) ? ST_END : ST_LED;
        end
      end
      ST_LED: begin
        if (load) begin
          out_word_nxt = {rlfb_pkg::LED_HEADER, rd_bright, rd_color};
          out_kind_nxt = rlfb_pkg::KIND_LED;
          out_last_nxt = 1'b0;
          idx_nxt      = led_next;
          rem_nxt      = rem_r - 6'd1;
          if (rem_r == 6'd1) begin
            state_nxt = ST_END;
          end
        end
      end
      ST_END: begin
        if (load) begin
          out_word_nxt = rlfb_pkg::END_WORD;
          out_kind_nxt = rlfb_pkg::KIND_END;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      len_r       <= len_nxt;
      bright_r    <= bright_nxt;
      out_word_r  <= out_word_nxt;
      out_kind_r  <= out_kind_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_word = out_word_r;
  assign out_word_kind  = out_kind_r;
  assign out_last_word  = out_last_r;

  a_no_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !load)
    else $error("frame word loaded while accepting requests");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == rlfb_pkg::KIND_END))
    else $error("last flag on a word that is not the end word");

  a_no_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_START) || (state_r == ST_LED) || (state_r == ST_END))
      |-> !(wr.wr_color || wr.wr_bright))
    else $error("store written while a frame is being sent");

  a_ring_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LED) |-> (idx_r < IdxW'(len_r)))
    else $error("ring position beyond ring length");

endmodule

`default_nettype wire

// ----- bench/tb_rgb_led_chain_frame_builder.sv -----
// Self-checking testbench for the LED chain frame builder.
`default_nettype none

module tb_rgb_led_chain_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 32;

  // Opcode 3 has no package name because the block ignores it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles to let pass after the last frame word before touching the registers.
  // A brightness request can keep the block busy without producing any output
  // word, so the pause must cover that.
  localparam int SETTLE_CYCLES = STORE_DEPTH + 8;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] position;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] brightness;
    logic [5:0] entry_count;
  } led_request_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  kind;
    logic        last;
  } frame_word_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode      = '0;
  logic [4:0]  in_position    = '0;
  logic [7:0]  in_red         = '0;
  logic [7:0]  in_green       = '0;
  logic [7:0]  in_blue        = '0;
  logic [4:0]  in_brightness  = '0;
  logic [5:0]  in_entry_count = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [31:0] out_frame_word;
  logic [1:0]  out_word_kind;
  logic        out_last_word;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_led_chain_frame_builder #(.STORE_DEPTH(STORE_DEPTH)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_brightness  (in_brightness),
    .in_entry_count (in_entry_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_word (out_frame_word),
    .out_word_kind  (out_word_kind),
    .out_last_word  (out_last_word),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Requests waiting to be driven, and the frame words the block still owes us.
  led_request_t request_queue[$];
  frame_word_t  expected_words[$];

  // Requests pushed by the sequence but not yet accepted by the block. This is
  // decremented at the accepting edge, in the same process that predicts the
  // frame, so once it reads zero every owed frame word is already queued.
  int requests_left = 0;
  int error_count   = 0;

  // When set, neither side idles.
  bit quiet = 1'b0;

  // Our own copy of the LED store and of the two registers.
  logic [28:0] store_copy [STORE_DEPTH];
  logic [5:0]  ring_length_copy = rlfb_pkg::RING_LENGTH_RST;
  logic [5:0]  led_count_copy   = rlfb_pkg::LED_COUNT_RST;

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_copy[i] = '0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Apply one accepted request to the store copy and queue the frame words it
  // causes. Only a send request produces words.
  task automatic apply_request(input led_request_t r);
    int          ring;
    int          leds;
    int          pos;
    int          count;
    logic [28:0] entry;
    case (r.opcode)
      rlfb_pkg::OP_WRITE: begin
        store_copy[r.position] = {r.brightness, r.blue, r.green, r.red};
      end
      rlfb_pkg::OP_BRIGHT: begin
        // Counts past the end of the store cover the whole store.
        count = (int'(r.entry_count) > STORE_DEPTH) ? STORE_DEPTH : int'(r.entry_count);
        for (int i = 0; i < count; i++) begin
          store_copy[i][28:24] = r.brightness;
        end
      end
      rlfb_pkg::OP_SEND: begin
        // A ring length of zero acts as one; lengths past the store saturate.
        ring = (ring_length_copy == 6'd0) ? 1 : int'(ring_length_copy);
        if (ring > STORE_DEPTH) ring = STORE_DEPTH;
        leds = (led_count_copy > rlfb_pkg::FRAME_LED_MAX) ? int'(rlfb_pkg::FRAME_LED_MAX)
                                                          : int'(led_count_copy);
        // A start position outside the ring restarts at entry zero.
        pos = (int'(r.position) >= ring) ? 0 : int'(r.position);
        expected_words.push_back('{word: rlfb_pkg::START_WORD, kind: rlfb_pkg::KIND_START,
                                   last: 1'b0});
        for (int i = 0; i < leds; i++) begin
          entry = store_copy[pos];
          expected_words.push_back('{word: {rlfb_pkg::LED_HEADER, entry[28:24], entry[23:0]},
                                     kind: rlfb_pkg::KIND_LED, last: 1'b0});
          pos++;
          if (pos >= ring) pos = 0;
        end
        expected_words.push_back('{word: rlfb_pkg::END_WORD, kind: rlfb_pkg::KIND_END,
                                   last: 1'b1});
      end
      default: begin
        // The unused opcode leaves everything as it was.
      end
    endcase
  endtask

  // Driver: predicts each request at the edge that accepts it, then either
  // presents the next pending request or, about 18 times in 100, idles.
  always @(posedge clk) begin
    led_request_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_request('{opcode: in_opcode, position: in_position, red: in_red,
                        green: in_green, blue: in_blue, brightness: in_brightness,
                        entry_count: in_entry_count});
        requests_left--;
      end
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 18)) begin
          nxt = request_queue.pop_front();
          in_valid       <= 1'b1;
          in_opcode      <= nxt.opcode;
          in_position    <= nxt.position;
          in_red         <= nxt.red;
          in_green       <= nxt.green;
          in_blue        <= nxt.blue;
          in_brightness  <= nxt.brightness;
          in_entry_count <= nxt.entry_count;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted frame word against the oldest one owed and
  // stalls the receiver at random.
  always @(posedge clk) begin
    frame_word_t exp_w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected word %08h kind %0d last %0b",
                           out_frame_word, out_word_kind, out_last_word));
        end else begin
          exp_w = expected_words.pop_front();
          if (out_frame_word !== exp_w.word)
            report($sformatf("frame_word %08h, wanted %08h", out_frame_word, exp_w.word));
          if (out_word_kind !== exp_w.kind)
            report($sformatf("word_kind %0d, wanted %0d", out_word_kind, exp_w.kind));
          if (out_last_word !== exp_w.last)
            report($sformatf("last_word %0b, wanted %0b", out_last_word, exp_w.last));
        end
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= 18);
    end
  end

  task automatic push_request(input led_request_t r);
    request_queue.push_back(r);
    requests_left++;
  endtask

  function automatic led_request_t make_request(input logic [1:0] op, input logic [4:0] pos,
                                                input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input logic [4:0] br,
                                                input logic [5:0] cnt);
    return '{opcode: op, position: pos, red: r, green: g, blue: b,
             brightness: br, entry_count: cnt};
  endfunction

  // Random request with fully random content. Most are writes and sends so the
  // store fills with varied data and frames read it back; a few are ignored.
  function automatic led_request_t random_request();
    int roll;
    led_request_t r;
    roll = $urandom_range(0, 99);
    r.opcode      = (roll < 40) ? rlfb_pkg::OP_WRITE : (roll < 55) ? rlfb_pkg::OP_BRIGHT :
                    (roll < 92) ? rlfb_pkg::OP_SEND : OP_UNUSED;
    r.position    = 5'($urandom_range(0, 31));
    r.red         = 8'($urandom);
    r.green       = 8'($urandom);
    r.blue        = 8'($urandom);
    r.brightness  = 5'($urandom_range(0, 31));
    r.entry_count = 6'($urandom_range(0, 63));
    return r;
  endfunction

  // Wait until every request is accepted and every frame word has come back,
  // then give a trailing brightness request time to finish.
  task automatic wait_idle();
    while (requests_left != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle held until pready.
  task automatic reg_write(input logic idx, input logic [5:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {26'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rlfb_pkg::REG_RING_LENGTH) ring_length_copy = value;
    else                                  led_count_copy   = value;
  endtask

  task automatic set_config(input logic [5:0] ring, input logic [5:0] leds);
    wait_idle();
    reg_write(rlfb_pkg::REG_RING_LENGTH, ring);
    reg_write(rlfb_pkg::REG_LED_COUNT, leds);
  endtask

  // Main sequence. The block runs a clearing pass after reset; the driver simply
  // waits on in_ready through it.
  initial begin
    int made;
    led_request_t r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: untouched entries, field extremes and all operations.
    push_request(make_request(rlfb_pkg::OP_SEND,   5'd0,  8'h00, 8'h00, 8'h00, 5'd0,  6'd0));
    push_request(make_request(rlfb_pkg::OP_WRITE,  5'd0,  8'hFF, 8'h00, 8'h00, 5'd31, 6'd63));
    push_request(make_request(rlfb_pkg::OP_WRITE,  5'd1,  8'h00, 8'hFF, 8'h00, 5'd0,  6'd0));
    push_request(make_request(rlfb_pkg::OP_WRITE,  5'd2,  8'h00, 8'h00, 8'hFF, 5'd16, 6'd32));
    push_request(make_request(rlfb_pkg::OP_WRITE,  5'd31, 8'hFF, 8'hFF, 8'hFF, 5'd31, 6'd1));
    push_request(make_request(rlfb_pkg::OP_WRITE,  5'd3,  8'hA5, 8'h5A, 8'hC3, 5'd10, 6'd21));
    push_request(make_request(rlfb_pkg::OP_SEND,   5'd0,  8'hFF, 8'hFF, 8'hFF, 5'd31, 6'd63));
    // Start on the last entry so the read wraps straight back to zero.
    push_request(make_request(rlfb_pkg::OP_SEND,   5'd31, 8'h00, 8'h00, 8'h00, 5'd0,  6'd0));
    // A brightness count of zero touches nothing.
    push_request(make_request(rlfb_pkg::OP_BRIGHT, 5'd7,  8'h12, 8'h34, 8'h56, 5'd31, 6'd0));
    push_request(make_request(rlfb_pkg::OP_BRIGHT, 5'd0,  8'h00, 8'h00, 8'h00, 5'd5,  6'd2));
    push_request(make_request(rlfb_pkg::OP_SEND,   5'd0,  8'h00, 8'h00, 8'h00, 5'd0,  6'd0));
    // A count past the end of the store covers the whole store.
    push_request(make_request(rlfb_pkg::OP_BRIGHT, 5'd31, 8'hFF, 8'hFF, 8'hFF, 5'd0,  6'd63));
    // The unused opcode must change nothing and produce nothing.
    push_request(make_request(OP_UNUSED,           5'd0,  8'hEE, 8'hDD, 8'hCC, 5'd9,  6'd4));
    push_request(make_request(rlfb_pkg::OP_SEND,   5'd30, 8'h00, 8'h00, 8'h00, 5'd0,  6'd0));
    push_request(make_request(rlfb_pkg::OP_BRIGHT, 5'd0,  8'h00, 8'h00, 8'h00, 5'd31, 6'd32));
    push_request(make_request(rlfb_pkg::OP_SEND,   5'd1,  8'h00, 8'h00, 8'h00, 5'd0,  6'd0));

    // Single-entry ring; a start position outside the ring restarts at zero.
    set_config(6'd1, 6'd3);
    push_request(make_request(rlfb_pkg::OP_SEND, 5'd0,  8'h00, 8'h00, 8'h00, 5'd0, 6'd0));
    push_request(make_request(rlfb_pkg::OP_SEND, 5'd20, 8'h00, 8'h00, 8'h00, 5'd0, 6'd0));

    // Ring length zero acts as one; a frame with no LED words.
    set_config(6'd0, 6'd0);
    push_request(make_request(rlfb_pkg::OP_SEND, 5'd7, 8'h00, 8'h00, 8'h00, 5'd0, 6'd0));

    // Full store and the largest frame.
    set_config(6'd32, 6'd32);
    push_request(make_request(rlfb_pkg::OP_SEND, 5'd17, 8'h00, 8'h00, 8'h00, 5'd0, 6'd0));

    // Both registers past their range saturate.
    set_config(6'd63, 6'd63);
    push_request(make_request(rlfb_pkg::OP_SEND, 5'd31, 8'h00, 8'h00, 8'h00, 5'd0, 6'd0));

    set_config(6'd5, 6'd33);
    push_request(make_request(rlfb_pkg::OP_SEND, 5'd4, 8'h00, 8'h00, 8'h00, 5'd0, 6'd0));
    push_request(make_request(rlfb_pkg::OP_SEND, 5'd5, 8'h00, 8'h00, 8'h00, 5'd0, 6'd0));

    // Random phases, each under a fresh setting. One phase runs without any
    // idling on either side. Each phase boundary holds the sender until the
    // block has drained.
    for (int phase = 0; phase < 6; phase++) begin
      set_config(6'($urandom_range(0, 40)), 6'($urandom_range(0, 36)));
      quiet = (phase == 2);
      made  = 0;
      while (made < 40) begin
        r = random_request();
        push_request(r);
        if (r.opcode != OP_UNUSED) made++;
      end
    end

    wait_idle();
    quiet = 1'b0;
    if (error_count == 0) begin
      $display("tb_rgb_led_chain_frame_builder: clean");
    end else begin
      $display("tb_rgb_led_chain_frame_builder: errors");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run needs.
  initial begin
    #2_000_000;
    $display("tb_rgb_led_chain_frame_builder: errors");
    $finish;
  end

endmodule

`default_nettype wire
